// File: hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation event statistics: shared package
// Defaults, op and record codes, sequencer states and the size-class table.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int SLOT_COUNT_DEF   = 24;
  localparam int TOP_REPORTED_DEF = 6;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int NUM_BINS    = 8;
  localparam int NUM_SUMMARY = 12;

  localparam logic [31:0] BIG_MIN_RESET = 32'd32768;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REPORT  = 2'd2;

  localparam logic [2:0] KIND_LIVE   = 3'd0;
  localparam logic [2:0] KIND_CALLS  = 3'd1;
  localparam logic [2:0] KIND_PEAK   = 3'd2;
  localparam logic [2:0] KIND_FAULTS = 3'd3;
  localparam logic [2:0] KIND_BIN    = 3'd4;
  localparam logic [2:0] KIND_BIG    = 3'd5;
  localparam logic [2:0] KIND_OVF    = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_REP_SCAN,
    ST_SUMMARY,
    ST_EMIT_BIG,
    ST_EMIT_OVF
  } aes_state_e;

  function automatic logic [2:0] size_class(input logic [31:0] sz);
    logic [2:0] c;
    if      (sz <= 32'd32)     c = 3'd0;
    else if (sz <= 32'd128)    c = 3'd1;
    else if (sz <= 32'd512)    c = 3'd2;
    else if (sz <= 32'd2048)   c = 3'd3;
    else if (sz <= 32'd8192)   c = 3'd4;
    else if (sz <= 32'd32768)  c = 3'd5;
    else if (sz <= 32'd131072) c = 3'd6;
    else                       c = 3'd7;
    return c;
  endfunction

endpackage

// File: hw/rtl/aes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/allocation_event_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocation event statistics
// Monitors allocator events; large sizes are tallied in a slot table that a
// small sequencer walks one entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op_i, size_i, valid_req_i) is taken when start is high and busy
//   is low. Alloc, release and unused ops finish in the accepting cycle,
//   except an alloc at or above big_min_size, which walks the slot RAM
//   with one RAM read per cycle.
//   A report emits 12 summary and bin items, then up to TOP_REPORTED large
//   sizes, largest first, and, if at least one large size is emitted, one
//   overflow item after them. Each largest size costs a full walk of the
//   slot RAM.
//   Results leave through registers, one per cycle while emitting, each
//   shown for one cycle under res_strobe_o; last_o marks the final one.
//   The receiver cannot stall the block.
//   big_min_size is written over cfg_valid_i/cfg_ready_o/cfg_data_i while
//   idle. Reset clears all counters and the slot valid bits; the slot RAM
//   needs no clearing pass and big_min_size returns to 32768.
// ----------------------------------------------------------------------------
module allocation_event_statistics #(
  parameter int SLOT_COUNT   = aes_pkg::SLOT_COUNT_DEF,
  parameter int TOP_REPORTED = aes_pkg::TOP_REPORTED_DEF,
  parameter int COUNTER_BITS = aes_pkg::COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] size_i,
  input  logic        valid_req_i,
  output logic        res_strobe_o,
  output logic [2:0]  record_kind_o,
  output logic [2:0]  record_index_o,
  output logic [31:0] value_a_o,
  output logic [31:0] value_b_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int CB      = COUNTER_BITS;
  localparam int WB      = (CB > 32) ? CB : 32;
  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W  = $clog2(SLOT_COUNT + 1);
  localparam int ROUND_W = $clog2(TOP_REPORTED + 1);
  localparam int RAM_W   = 32 + CB;

  function automatic logic [31:0] lo32(input logic [CB-1:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    return w[31:0];
  endfunction

  aes_pkg::aes_state_e state_q, state_d;

  logic [31:0]         big_min_q, big_min_d;
  logic [CB-1:0]       live_bytes_q, live_bytes_d;
  logic [CB-1:0]       live_count_q, live_count_d;
  logic [CB-1:0]       alloc_calls_q, alloc_calls_d;
  logic [CB-1:0]       release_calls_q, release_calls_d;
  logic [31:0]         largest_q, largest_d;
  logic [CB-1:0]       peak_q, peak_d;
  logic [CB-1:0]       foreign_q, foreign_d;
  logic [CB-1:0]       failures_q, failures_d;
  logic [CB-1:0]       ovf_q, ovf_d;
  logic [CB-1:0]       bins_q [aes_pkg::NUM_BINS];
  logic [CB-1:0]       bins_d [aes_pkg::NUM_BINS];
  logic [SLOT_COUNT-1:0] slot_vld_q, slot_vld_d;

  logic [31:0]         size_q, size_d;
  logic [SCAN_W-1:0]   scan_idx_q, scan_idx_d;
  logic                chk_vld_q, chk_vld_d;
  logic [SLOT_AW-1:0]  chk_idx_q, chk_idx_d;
  logic                best_found_q, best_found_d;
  logic [SLOT_AW-1:0]  best_idx_q, best_idx_d;
  logic [31:0]         best_size_q, best_size_d;
  logic [CB-1:0]       best_cnt_q, best_cnt_d;
  logic [ROUND_W-1:0]  round_q, round_d;
  logic [3:0]          emit_q, emit_d;

  logic        strobe_q, strobe_d;
  logic [2:0]  kind_q, kind_d;
  logic [2:0]  index_q, index_d;
  logic [31:0] val_a_q, val_a_d;
  logic [31:0] val_b_q, val_b_d;
  logic        last_q, last_d;

  logic               accept;
  logic               scan_end;
  logic               scan_enter;
  logic               do_clear;
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;
  logic [31:0]        rd_size;
  logic [CB-1:0]      rd_cnt;
  logic               rd_occ;
  logic               alloc_hit;
  logic               better;
  logic [2:0]         bin_sel;
  logic [2:0]         cls;
  logic [WB-1:0]      lb_ext;
  logic [WB-1:0]      sz_ext;
  logic [CB-1:0]      lb_add;

  assign accept      = start && !busy;
  assign busy        = (state_q != aes_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == aes_pkg::ST_IDLE);

  // slot RAM and the shared compare unit
  aes_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chk_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_size   = ram_rdata[31:0];
  assign rd_cnt    = ram_rdata[RAM_W-1:32];
  assign rd_occ    = slot_vld_q[chk_idx_q] && (rd_cnt != '0);
  assign alloc_hit = chk_vld_q && (!rd_occ || (rd_size == size_q));
  assign better    = chk_vld_q && rd_occ && (!best_found_q || (rd_size > best_size_q));
  assign scan_end  = (scan_idx_q == SCAN_W'(SLOT_COUNT)) && !chk_vld_q;
  assign ram_raddr = scan_idx_q[SLOT_AW-1:0];
  assign ram_wdata = {(rd_occ ? rd_cnt + CB'(1) : CB'(1)), size_q};
  assign ram_we    = (state_q == aes_pkg::ST_ALLOC_SCAN) && alloc_hit;

  assign bin_sel = 3'(emit_q - 4'd4);
  assign cls     = aes_pkg::size_class(size_i);
  assign lb_ext  = WB'(live_bytes_q);
  assign sz_ext  = WB'(size_i);
  assign lb_add  = live_bytes_q + CB'(size_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == aes_pkg::OP_ALLOC && size_i >= big_min_q) begin
            state_d = aes_pkg::ST_ALLOC_SCAN;
          end else if (op_i == aes_pkg::OP_REPORT) begin
            state_d = aes_pkg::ST_REP_SCAN;
          end
        end
      end
      aes_pkg::ST_ALLOC_SCAN: begin
        if (alloc_hit || scan_end) begin
          state_d = aes_pkg::ST_IDLE;
        end
      end
      aes_pkg::ST_REP_SCAN: begin
        if (scan_end) begin
          if (round_q == '0) begin
            state_d = aes_pkg::ST_SUMMARY;
          end else if (best_found_q) begin
            state_d = aes_pkg::ST_EMIT_BIG;
          end else begin
            state_d = aes_pkg::ST_EMIT_OVF;
          end
        end
      end
      aes_pkg::ST_SUMMARY: begin
        if (emit_q == 4'(aes_pkg::NUM_SUMMARY - 1)) begin
          state_d = best_found_q ? aes_pkg::ST_EMIT_BIG : aes_pkg::ST_IDLE;
        end
      end
      aes_pkg::ST_EMIT_BIG: begin
        if (round_q == ROUND_W'(TOP_REPORTED - 1)) begin
          state_d = aes_pkg::ST_EMIT_OVF;
        end else begin
          state_d = aes_pkg::ST_REP_SCAN;
        end
      end
      aes_pkg::ST_EMIT_OVF: begin
        state_d = aes_pkg::ST_IDLE;
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: result item and control
  always_comb begin
    strobe_d   = 1'b0;
    kind_d     = aes_pkg::KIND_LIVE;
    index_d    = '0;
    val_a_d    = '0;
    val_b_d    = '0;
    last_d     = 1'b0;
    do_clear   = 1'b0;
    scan_enter = 1'b0;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        scan_enter = accept;
      end
      aes_pkg::ST_SUMMARY: begin
        strobe_d = 1'b1;
        unique case (emit_q)
          4'd0: begin
            kind_d  = aes_pkg::KIND_LIVE;
            val_a_d = lo32(live_bytes_q);
            val_b_d = lo32(live_count_q);
          end
          4'd1: begin
            kind_d  = aes_pkg::KIND_CALLS;
            val_a_d = lo32(alloc_calls_q);
            val_b_d = lo32(release_calls_q);
          end
          4'd2: begin
            kind_d  = aes_pkg::KIND_PEAK;
            val_a_d = largest_q;
            val_b_d = lo32(peak_q);
          end
          4'd3: begin
            kind_d  = aes_pkg::KIND_FAULTS;
            val_a_d = lo32(foreign_q);
            val_b_d = lo32(failures_q);
          end
          default: begin
            kind_d  = aes_pkg::KIND_BIN;
            index_d = bin_sel;
            val_a_d = lo32(bins_q[bin_sel]);
          end
        endcase
        if (emit_q == 4'(aes_pkg::NUM_SUMMARY - 1) && !best_found_q) begin
          last_d   = 1'b1;
          do_clear = 1'b1;
        end
      end
      aes_pkg::ST_EMIT_BIG: begin
        strobe_d   = 1'b1;
        kind_d     = aes_pkg::KIND_BIG;
        index_d    = 3'(round_q);
        val_a_d    = best_size_q;
        val_b_d    = lo32(best_cnt_q);
        scan_enter = 1'b1;
      end
      aes_pkg::ST_EMIT_OVF: begin
        strobe_d = 1'b1;
        kind_d   = aes_pkg::KIND_OVF;
        val_a_d  = lo32(ovf_q);
        last_d   = 1'b1;
        do_clear = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    big_min_d       = big_min_q;
    live_bytes_d    = live_bytes_q;
    live_count_d    = live_count_q;
    alloc_calls_d   = alloc_calls_q;
    release_calls_d = release_calls_q;
    largest_d       = largest_q;
    peak_d          = peak_q;
    foreign_d       = foreign_q;
    failures_d      = failures_q;
    ovf_d           = ovf_q;
    bins_d          = bins_q;
    slot_vld_d      = slot_vld_q;
    size_d          = size_q;
    scan_idx_d      = scan_idx_q;
    chk_vld_d       = 1'b0;
    chk_idx_d       = chk_idx_q;
    best_found_d    = best_found_q;
    best_idx_d      = best_idx_q;
    best_size_d     = best_size_q;
    best_cnt_d      = best_cnt_q;
    round_d         = round_q;
    emit_d          = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      big_min_d = cfg_data_i;
    end

    if (accept) begin
      size_d  = size_i;
      round_d = '0;
      if (op_i == aes_pkg::OP_ALLOC) begin
        if (valid_req_i) begin
          live_bytes_d  = lb_add;
          live_count_d  = live_count_q + CB'(1);
          alloc_calls_d = alloc_calls_q + CB'(1);
          bins_d[cls]   = bins_q[cls] + CB'(1);
          if (size_i > largest_q) largest_d = size_i;
          if (lb_add > peak_q) peak_d = lb_add;
        end else begin
          failures_d = failures_q + CB'(1);
        end
      end else if (op_i == aes_pkg::OP_RELEASE) begin
        if (valid_req_i) begin
          live_bytes_d    = (lb_ext >= sz_ext) ? CB'(lb_ext - sz_ext) : '0;
          live_count_d    = (live_count_q != '0) ? live_count_q - CB'(1) : '0;
          release_calls_d = release_calls_q + CB'(1);
        end else begin
          foreign_d = foreign_q + CB'(1);
        end
      end
    end

    if (scan_enter) begin
      scan_idx_d   = '0;
      best_found_d = 1'b0;
    end else if (state_q == aes_pkg::ST_ALLOC_SCAN || state_q == aes_pkg::ST_REP_SCAN) begin
      if (scan_idx_q != SCAN_W'(SLOT_COUNT)) begin
        scan_idx_d = scan_idx_q + SCAN_W'(1);
        chk_vld_d  = 1'b1;
        chk_idx_d  = scan_idx_q[SLOT_AW-1:0];
      end
    end

    if (state_q == aes_pkg::ST_ALLOC_SCAN) begin
      if (alloc_hit) begin
        slot_vld_d[chk_idx_q] = 1'b1;
      end else if (scan_end) begin
        ovf_d = ovf_q + CB'(1);
      end
    end

    if (state_q == aes_pkg::ST_REP_SCAN && better) begin
      best_found_d = 1'b1;
      best_idx_d   = chk_idx_q;
      best_size_d  = rd_size;
      best_cnt_d   = rd_cnt;
    end

    if (state_q == aes_pkg::ST_SUMMARY) begin
      emit_d = emit_q + 4'd1;
    end

    if (state_q == aes_pkg::ST_EMIT_BIG) begin
      slot_vld_d[best_idx_q] = 1'b0;
      round_d                = round_q + ROUND_W'(1);
    end

    if (do_clear) begin
      alloc_calls_d   = '0;
      release_calls_d = '0;
      ovf_d           = '0;
      slot_vld_d      = '0;
      for (int b = 0; b < aes_pkg::NUM_BINS; b++) begin
        bins_d[b] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= aes_pkg::ST_IDLE;
      big_min_q       <= aes_pkg::BIG_MIN_RESET;
      live_bytes_q    <= '0;
      live_count_q    <= '0;
      alloc_calls_q   <= '0;
      release_calls_q <= '0;
      largest_q       <= '0;
      peak_q          <= '0;
      foreign_q       <= '0;
      failures_q      <= '0;
      ovf_q           <= '0;
      for (int b = 0; b < aes_pkg::NUM_BINS; b++) begin
        bins_q[b] <= '0;
      end
      slot_vld_q      <= '0;
      size_q          <= '0;
      scan_idx_q      <= '0;
      chk_vld_q       <= 1'b0;
      chk_idx_q       <= '0;
      best_found_q    <= 1'b0;
      best_idx_q      <= '0;
      best_size_q     <= '0;
      best_cnt_q      <= '0;
      round_q         <= '0;
      emit_q          <= '0;
      strobe_q        <= 1'b0;
      kind_q          <= '0;
      index_q         <= '0;
      val_a_q         <= '0;
      val_b_q         <= '0;
      last_q          <= 1'b0;
    end else begin
      state_q         <= state_d;
      big_min_q       <= big_min_d;
      live_bytes_q    <= live_bytes_d;
      live_count_q    <= live_count_d;
      alloc_calls_q   <= alloc_calls_d;
      release_calls_q <= release_calls_d;
      largest_q       <= largest_d;
      peak_q          <= peak_d;
      foreign_q       <= foreign_d;
      failures_q      <= failures_d;
      ovf_q           <= ovf_d;
      bins_q          <= bins_d;
      slot_vld_q      <= slot_vld_d;
      size_q          <= size_d;
      scan_idx_q      <= scan_idx_d;
      chk_vld_q       <= chk_vld_d;
      chk_idx_q       <= chk_idx_d;
      best_found_q    <= best_found_d;
      best_idx_q      <= best_idx_d;
      best_size_q     <= best_size_d;
      best_cnt_q      <= best_cnt_d;
      round_q         <= round_d;
      emit_q          <= emit_d;
      strobe_q        <= strobe_d;
      kind_q          <= kind_d;
      index_q         <= index_d;
      val_a_q         <= val_a_d;
      val_b_q         <= val_b_d;
      last_q          <= last_d;
    end
  end

  assign res_strobe_o   = strobe_q;
  assign record_kind_o  = kind_q;
  assign record_index_o = index_q;
  assign value_a_o      = val_a_q;
  assign value_b_o      = val_b_q;
  assign last_o         = last_q;

  // the final item of a report leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && last_q |-> state_q == aes_pkg::ST_IDLE)
    else $error("report ended with sequencer still busy");

  // an overflow item always closes the report
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && kind_q == aes_pkg::KIND_OVF |-> last_q)
    else $error("overflow item not marked last");

  // only a report may leave the idle state for the report walk of the slot table
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aes_pkg::ST_IDLE && state_d == aes_pkg::ST_REP_SCAN
      |-> accept && op_i == aes_pkg::OP_REPORT)
    else $error("report walk started without a report item");

endmodule
